// ----- rtl/core/hts_pkg.sv -----
// Package for the HTML tag stripper with entity decode.
// Holds the entity table, character codes and the queue entry type.
// No dependencies.
package hts_pkg;

  localparam int NUM_ENT      = 6;
  localparam int PREFIX_DEPTH = 5;
  localparam int MAX_RES      = 6;
  localparam int CNT_W        = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_AMP = 8'h26;

  // Entity indexes, in match priority order.
  localparam logic [2:0] ENT_AMP  = 3'd0;
  localparam logic [2:0] ENT_QUOT = 3'd1;
  localparam logic [2:0] ENT_APOS = 3'd2;
  localparam logic [2:0] ENT_LT   = 3'd3;
  localparam logic [2:0] ENT_GT   = 3'd4;
  localparam logic [2:0] ENT_NBSP = 3'd5;

  // Match result of the held prefix plus the incoming byte.
  localparam logic [1:0] MATCH_NONE = 2'd0;
  localparam logic [1:0] MATCH_PART = 2'd1;
  localparam logic [1:0] MATCH_FULL = 2'd2;

  // One request's worth of results, queued between front and back.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] res_bytes;
    logic [CNT_W-1:0]        res_count;
    logic                    last;
  } hts_entry_t;

  // Entity text, first character in the top byte, zero padded.
  function automatic logic [47:0] ent_text(input logic [2:0] k);
    logic [47:0] t;
    unique case (k)
      ENT_AMP:  t = {"&amp;", 8'h00};
      ENT_QUOT: t = "&quot;";
      ENT_APOS: t = "&apos;";
      ENT_LT:   t = {"&lt;", 16'h0000};
      ENT_GT:   t = {"&gt;", 16'h0000};
      ENT_NBSP: t = "&nbsp;";
      default:  t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] ent_len(input logic [2:0] k);
    logic [2:0] n;
    unique case (k)
      ENT_AMP:  n = 3'd5;
      ENT_QUOT: n = 3'd6;
      ENT_APOS: n = 3'd6;
      ENT_LT:   n = 3'd4;
      ENT_GT:   n = 3'd4;
      ENT_NBSP: n = 3'd6;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] ent_decoded(input logic [2:0] k);
    logic [7:0] d;
    unique case (k)
      ENT_AMP:  d = 8'h26;
      ENT_QUOT: d = 8'h22;
      ENT_APOS: d = 8'h27;
      ENT_LT:   d = 8'h3C;
      ENT_GT:   d = 8'h3E;
      ENT_NBSP: d = 8'h20;
      default:  d = 8'h00;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/core/hts_if.sv -----
// Valid/ready stream interfaces for the tag stripper.
// Input carries raw bytes, output carries plain-text results. No dependencies.
interface hts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;
  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface hts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       out_last;
  modport source (output valid, output out_char, output char_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_char, input char_valid, input out_last,
                  output ready);
endinterface

// ----- rtl/core/hts_front.sv -----
// Front end: accepts bytes, tracks tag and entity prefix state, and builds
// the list of results each byte causes. Uses hts_pkg and hts_in_if.
module hts_front (
  input  logic                clk,
  input  logic                rst_n,
  hts_in_if.sink              in_chan,
  input  logic                q_full,
  output logic                push,
  output hts_pkg::hts_entry_t push_entry
);

  logic                      accept;
  logic                      tag_r, tag_nxt;
  logic [hts_pkg::CNT_W-1:0] pcount_r, pcount_nxt;
  logic [7:0]                prefix_r   [hts_pkg::PREFIX_DEPTH];
  logic [7:0]                prefix_nxt [hts_pkg::PREFIX_DEPTH];
  logic [1:0]                match;
  logic [2:0]                match_idx;
  logic [hts_pkg::MAX_RES-1:0][7:0] rb;
  logic [hts_pkg::CNT_W-1:0]        rc;
  logic [hts_pkg::CNT_W-1:0]        rc_base;
  logic                             plain_go;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;

  // Lowest-indexed entity that agrees with held prefix plus this byte wins.
  always_comb begin
    logic        ok;
    logic [47:0] txt;
    logic [3:0]  len;
    match     = hts_pkg::MATCH_NONE;
    match_idx = '0;
    for (int k = hts_pkg::NUM_ENT - 1; k >= 0; k--) begin
      txt = hts_pkg::ent_text(3'(k));
      len = {1'b0, hts_pkg::ent_len(3'(k))};
      ok  = ({1'b0, pcount_r} + 4'd1) <= len;
      for (int i = 0; i < hts_pkg::PREFIX_DEPTH; i++) begin
        if ((3'(i) < pcount_r) && (prefix_r[i] != txt[47 - 8*i -: 8])) ok = 1'b0;
      end
      if (ok && (txt[47 - 8*int'(pcount_r) -: 8] != in_chan.in_char)) ok = 1'b0;
      if (ok) begin
        match_idx = 3'(k);
        match     = (({1'b0, pcount_r} + 4'd1) == len) ? hts_pkg::MATCH_FULL
                                                       : hts_pkg::MATCH_PART;
      end
    end
  end

  always_comb begin
    tag_nxt    = tag_r;
    pcount_nxt = pcount_r;
    prefix_nxt = prefix_r;
    rb         = '0;
    rc         = '0;
    rc_base    = '0;
    plain_go   = 1'b0;
    if (tag_r) begin
      if (in_chan.in_char == hts_pkg::CH_GT) tag_nxt = 1'b0;
    end else if (pcount_r != '0) begin
      if (match == hts_pkg::MATCH_FULL) begin
        rb[0]      = hts_pkg::ent_decoded(match_idx);
        rc         = 3'd1;
        pcount_nxt = '0;
      end else if ((match == hts_pkg::MATCH_PART) &&
                   (pcount_r < 3'(hts_pkg::PREFIX_DEPTH))) begin
        prefix_nxt[pcount_r] = in_chan.in_char;
        pcount_nxt           = pcount_r + 3'd1;
      end else begin
        // Broken prefix: release held bytes, then treat the byte as fresh.
        for (int p = 0; p < hts_pkg::PREFIX_DEPTH; p++) begin
          if (3'(p) < pcount_r) rb[p] = prefix_r[p];
        end
        rc         = pcount_r;
        pcount_nxt = '0;
        plain_go   = 1'b1;
      end
    end else begin
      plain_go = 1'b1;
    end

    if (plain_go) begin
      if (in_chan.in_char == hts_pkg::CH_LT) begin
        tag_nxt = 1'b1;
      end else if (in_chan.in_char == hts_pkg::CH_AMP) begin
        prefix_nxt[0] = in_chan.in_char;
        pcount_nxt    = 3'd1;
      end else begin
        rb[rc] = in_chan.in_char;
        rc     = rc + 3'd1;
      end
    end

    // End of text: flush whatever prefix is still held.
    if (in_chan.in_last) begin
      rc_base = rc;
      for (int p = 0; p < hts_pkg::MAX_RES; p++) begin
        for (int j = 0; j < hts_pkg::PREFIX_DEPTH; j++) begin
          if ((3'(j) < pcount_nxt) && ((int'(rc_base) + j) == p)) rb[p] = prefix_nxt[j];
        end
      end
      rc         = rc_base + pcount_nxt;
      tag_nxt    = 1'b0;
      pcount_nxt = '0;
    end
  end

  assign push                 = accept && ((rc != '0) || in_chan.in_last);
  assign push_entry.res_bytes = rb;
  assign push_entry.res_count = rc;
  assign push_entry.last      = in_chan.in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r    <= 1'b0;
      pcount_r <= '0;
    end else if (accept) begin
      tag_r    <= tag_nxt;
      pcount_r <= pcount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) prefix_r <= prefix_nxt;
  end

`ifndef SYNTHESIS
  a_tag_prefix_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(tag_r && (pcount_r != '0)))
    else $error("tag and entity prefix active together");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.in_last) |=> (!tag_r && (pcount_r == '0)))
    else $error("state not cleared after end of text");
`endif

endmodule

// ----- rtl/core/hts_queue.sv -----
// Short FIFO of result lists between the front and back ends.
// Uses hts_pkg.
module hts_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hts_pkg::hts_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output hts_pkg::hts_entry_t head
);

  hts_pkg::hts_entry_t        mem_r [hts_pkg::QUEUE_DEPTH];
  logic [hts_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [hts_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == hts_pkg::QCNT_W'(hts_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= hts_pkg::QCNT_W'(hts_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ----- rtl/core/hts_back.sv -----
// Back end: walks the head result list one byte per cycle, while the output is not
// stalled, into a registered output stage. Uses hts_pkg and hts_out_if.
module hts_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  hts_pkg::hts_entry_t head,
  output logic                pop,
  hts_out_if.source           out_chan
);

  logic [hts_pkg::CNT_W-1:0] idx_r;
  logic                      ov_r;
  logic [7:0]                char_r;
  logic                      cvalid_r;
  logic                      last_r;
  logic                      fire;
  logic                      last_res;

  assign fire     = head_valid && (!ov_r || out_chan.ready);
  assign last_res = (head.res_count == '0) || (idx_r == (head.res_count - 3'd1));
  assign pop      = fire && last_res;

  assign out_chan.valid      = ov_r;
  assign out_chan.out_char   = char_r;
  assign out_chan.char_valid = cvalid_r;
  assign out_chan.out_last   = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      if (fire) ov_r <= 1'b1;
      else if (out_chan.ready) ov_r <= 1'b0;
      if (fire) idx_r <= last_res ? '0 : idx_r + 3'd1;
    end
  end

  // A list with no bytes is a bare end marker.
  always_ff @(posedge clk) begin
    if (fire) begin
      char_r   <= (head.res_count == '0) ? 8'h00 : head.res_bytes[idx_r];
      cvalid_r <= (head.res_count != '0);
      last_r   <= head.last && last_res;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && (head.res_count != '0)) |-> (idx_r < head.res_count))
    else $error("result index beyond list");
`endif

endmodule

// ----- rtl/core/html_tag_strip_entity_decode.sv -----
// HTML tag stripper with entity decode: drops tags, decodes six named entities.
// The first result of a request passes through the queue and the registered output stage.
// Throughput: one request per cycle while each yields at most one result and the
// output is not stalled; a request yielding n results sends n outputs; four queued lists.
// Reset (synchronous, active low) clears tag/prefix state, queue and output.
// Uses hts_pkg, hts_if, hts_front, hts_queue and hts_back.
module html_tag_strip_entity_decode (
  input  logic       clk,
  input  logic       rst_n,
  hts_in_if.sink     in_chan,
  hts_out_if.source  out_chan
);

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_head_valid;
  hts_pkg::hts_entry_t q_push_entry;
  hts_pkg::hts_entry_t q_head;

  hts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  hts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  hts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_chan   (out_chan)
  );

endmodule

// ----- test/hts_tb_pkg.sv -----
// Scoreboard for the tag stripper testbench: predicts plain-text results per request
// and checks them in order. Depends on hts_pkg.
package hts_tb_pkg;
  import hts_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
    logic       last;
  } text_res_t;

  function automatic string entity_text(input logic [2:0] k);
    case (k)
      ENT_AMP:  return "&amp;";
      ENT_QUOT: return "&quot;";
      ENT_APOS: return "&apos;";
      ENT_LT:   return "&lt;";
      ENT_GT:   return "&gt;";
      ENT_NBSP: return "&nbsp;";
      default:  return "";
    endcase
  endfunction

  class plain_text_scoreboard;
    logic       in_tag;
    logic [7:0] held [PREFIX_DEPTH];
    int         held_n;
    text_res_t  step_out[$];
    text_res_t  expected_text[$];
    int         errors;

    function new();
      in_tag = 1'b0;
      held_n = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_text.size();
    endfunction

    function logic [7:0] decoded_char(input logic [2:0] k);
      case (k)
        ENT_AMP:  return CH_AMP;
        ENT_QUOT: return 8'h22;
        ENT_APOS: return 8'h27;
        ENT_LT:   return CH_LT;
        ENT_GT:   return CH_GT;
        ENT_NBSP: return 8'h20;
        default:  return 8'h00;
      endcase
    endfunction

    function void put_char(input logic [7:0] ch);
      text_res_t r;
      r = '{ch: ch, vld: 1'b1, last: 1'b0};
      step_out.insert(step_out.size(), r);
    endfunction

    function void flush_held();
      for (int i = 0; i < held_n; i++) put_char(held[i]);
      held_n = 0;
    endfunction

    function void take_plain(input logic [7:0] ch);
      if (ch == CH_LT) begin
        in_tag = 1'b1;
      end else if (ch == CH_AMP) begin
        held[0] = ch;
        held_n  = 1;
      end else begin
        put_char(ch);
      end
    endfunction

    // First entity in priority order whose text continues the held prefix with ch.
    function logic [1:0] find_entity(input logic [7:0] ch, output logic [2:0] k_hit);
      string t;
      bit    ok;
      k_hit = ENT_AMP;
      for (int k = 0; k < NUM_ENT; k++) begin
        t = entity_text(3'(k));
        if (held_n + 1 > t.len()) continue;
        ok = 1'b1;
        for (int i = 0; i < held_n; i++)
          if (held[i] != t[i]) ok = 1'b0;
        if (!ok || t[held_n] != ch) continue;
        k_hit = 3'(k);
        return (held_n + 1 == t.len()) ? MATCH_FULL : MATCH_PART;
      end
      return MATCH_NONE;
    endfunction

    function void accept_byte(input logic [7:0] ch, input logic last_mark);
      logic [1:0] m;
      logic [2:0] k;
      text_res_t  bare;
      step_out.delete();
      if (in_tag) begin
        if (ch == CH_GT) in_tag = 1'b0;
      end else if (held_n > 0) begin
        m = find_entity(ch, k);
        if (m == MATCH_FULL) begin
          put_char(decoded_char(k));
          held_n = 0;
        end else if (m == MATCH_PART && held_n < PREFIX_DEPTH) begin
          held[held_n] = ch;
          held_n++;
        end else begin
          // release the broken prefix, then treat ch as a fresh byte
          flush_held();
          take_plain(ch);
        end
      end else begin
        take_plain(ch);
      end
      if (last_mark) begin
        flush_held();
        in_tag = 1'b0;
        if (step_out.size() == 0) begin
          bare = '{ch: 8'h00, vld: 1'b0, last: 1'b0};
          step_out.insert(0, bare);
        end
        step_out[step_out.size() - 1].last = 1'b1;
      end
      foreach (step_out[i]) expected_text.insert(expected_text.size(), step_out[i]);
    endfunction

    function void check_char(input logic [7:0] ch, input logic vld, input logic last);
      text_res_t exp_res;
      if (expected_text.size() == 0) begin
        $error("unexpected result: out_char %h char_valid %b out_last %b", ch, vld, last);
        errors++;
        return;
      end
      exp_res = expected_text.pop_front();
      if (ch !== exp_res.ch) begin
        $error("out_char mismatch: expected %h, got %h", exp_res.ch, ch);
        errors++;
      end
      if (vld !== exp_res.vld) begin
        $error("char_valid mismatch: expected %b, got %b", exp_res.vld, vld);
        errors++;
      end
      if (last !== exp_res.last) begin
        $error("out_last mismatch: expected %b, got %b", exp_res.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- test/tb.sv -----
// Top-level testbench for html_tag_strip_entity_decode: directed and random byte
// streams with random stalls on both channels. Depends on hts_pkg, hts_if, hts_tb_pkg.
module tb;
  import hts_pkg::*;
  import hts_tb_pkg::*;

  logic clk;
  logic rst_n;

  hts_in_if  in_ch();
  hts_out_if out_ch();

  html_tag_strip_entity_decode DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  plain_text_scoreboard sb = new();

  int bytes_sent  = 0;
  int idle_burst  = 0;
  int ready_run   = 0;
  int ready_roll;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("html_tag_strip_entity_decode regression: fail");
    $finish;
  end

  // Result side: random backpressure, mostly short stalls, a few long ones.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 60) begin
        out_ch.ready <= 1'b1;
        ready_run    <= $urandom_range(0, 8);
      end else if (ready_roll < 68) begin
        out_ch.ready <= 1'b1;
        ready_run    <= $urandom_range(40, 120);
      end else if (ready_roll < 95) begin
        out_ch.ready <= 1'b0;
        ready_run    <= $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b0;
        ready_run    <= $urandom_range(10, 30);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_char(out_ch.out_char, out_ch.char_valid, out_ch.out_last);
  end

  function automatic int idle_cycles();
    int r;
    if (idle_burst > 0) begin
      idle_burst--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) idle_burst = $urandom_range(30, 80);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Present one byte, hold until accepted, then optionally drop valid for a gap.
  task automatic send_byte(input logic [7:0] ch, input logic last_mark);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.in_char <= ch;
    in_ch.in_last <= last_mark;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.accept_byte(ch, last_mark);
    bytes_sent++;
    gap = idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s, input logic end_mark);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], end_mark && (i == s.len() - 1));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] seg[$];
    string      txt;
    int         kind;
    int         cut;
    int         wait_n;
    bit         end_text;
    bit         drained;

    drained       = 1'b0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_char = 8'h00;
    in_ch.in_last = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, tags, entities, broken prefixes, end cases
    send_byte(8'hFF, 1'b0);
    send_text("<b&>", 1'b0);
    send_text("&quot;", 1'b0);
    send_text("&am<i>", 1'b0);
    send_text("&&lt", 1'b1);
    send_byte(8'h00, 1'b0);
    send_text("<x", 1'b1);
    drain_results();

    while (bytes_sent < 330) begin
      seg.delete();
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: repeat ($urandom_range(1, 3)) seg.insert(seg.size(), 8'($urandom_range(0, 255)));
        2, 3: begin
          txt = entity_text(3'($urandom_range(0, NUM_ENT - 1)));
          for (int i = 0; i < txt.len(); i++) seg.insert(seg.size(), txt[i]);
        end
        4, 5: begin
          txt = entity_text(3'($urandom_range(0, NUM_ENT - 1)));
          cut = $urandom_range(1, txt.len() - 1);
          for (int i = 0; i < cut; i++) seg.insert(seg.size(), txt[i]);
          case ($urandom_range(0, 3))
            0:       seg.insert(seg.size(), CH_LT);
            1:       seg.insert(seg.size(), CH_AMP);
            default: seg.insert(seg.size(), 8'($urandom_range(0, 255)));
          endcase
        end
        6: begin
          seg.insert(seg.size(), CH_LT);
          repeat ($urandom_range(0, 4)) seg.insert(seg.size(), 8'($urandom_range(0, 255)));
          seg.insert(seg.size(), CH_GT);
        end
        7: repeat ($urandom_range(1, 6)) seg.insert(seg.size(), 8'($urandom_range(32, 126)));
        8: begin
          seg.insert(seg.size(), CH_AMP);
          seg.insert(seg.size(), CH_AMP);
          seg.insert(seg.size(), 8'($urandom_range(32, 126)));
        end
        default: seg.insert(seg.size(), CH_LT);
      endcase
      end_text = ($urandom_range(0, 5) == 0);
      foreach (seg[i]) send_byte(seg[i], end_text && (i == seg.size() - 1));
      if (!drained && bytes_sent >= 170) begin
        drain_results();
        drained = 1'b1;
      end
    end
    send_byte(8'h2E, 1'b1);
    in_ch.valid <= 1'b0;

    for (wait_n = 0; sb.pending() != 0 && wait_n < 50000; wait_n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      $error("%0d expected results never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("html_tag_strip_entity_decode regression: pass");
    end else begin
      $display("html_tag_strip_entity_decode regression: fail");
    end
    $finish;
  end

endmodule
